// File: src/tpc_pkg.sv
// shared types and constants for the triangle plane clipper
// used by every design module of the block; no dependencies
`default_nettype none
package tpc_pkg;
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int T_FRAC = 30;
  localparam int DOT_W_DEF = 66 - COORD_FRAC_BITS_DEF;
  localparam int CROSS_LAT = T_FRAC + 2;

  typedef logic signed [31:0] coord_t;
  typedef coord_t [3:0] vert_t;      // index 0 = x, 1 = y, 2 = z, 3 = w
  typedef logic signed [32:0] delta_t;
  typedef delta_t [3:0] dvec_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ONE,
    KIND_TWO,
    KIND_ALL
  } kind_t;

  typedef struct packed {
    kind_t kind;
    vert_t p0;
    vert_t p1;
    vert_t p2;
  } pass_t;

  typedef struct packed {
    logic [1:0] corner;
    logic       second;
    logic       last;
  } tag_t;
endpackage
`default_nettype wire

// File: src/tpc_dot.sv
// one dot product lane: vertex against plane, two register stages
// depends on tpc_pkg
`default_nettype none
module tpc_dot #(
  parameter int COORD_FRAC_BITS = tpc_pkg::COORD_FRAC_BITS_DEF,
  parameter int DOT_W = tpc_pkg::DOT_W_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire tpc_pkg::vert_t          vert,
  input  wire tpc_pkg::vert_t          plane,
  output logic signed [DOT_W-1:0]      dot,
  output tpc_pkg::vert_t               vert_q
);
  import tpc_pkg::*;

  logic signed [63:0] prod [4];
  vert_t              vert_1;
  logic signed [DOT_W-1:0] sum;

  // floor shift of each product, exact sum
  always_comb begin
    sum = '0;
    for (int k = 0; k < 4; k++) begin
      sum = sum + DOT_W'(prod[k] >>> COORD_FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        prod[k] <= 64'($signed(vert[k]) * $signed(plane[k]));
      end
      vert_1 <= vert;
      dot    <= sum;
      vert_q <= vert_1;
    end
  end
endmodule
`default_nettype wire

// File: src/tpc_cross.sv
// one edge crossing lane: pipelined restoring divider for t, then interpolation
// depends on tpc_pkg
`default_nettype none
module tpc_cross #(
  parameter int DOT_W = tpc_pkg::DOT_W_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire tpc_pkg::vert_t          pin,
  input  wire tpc_pkg::vert_t          pout,
  input  wire logic signed [DOT_W-1:0] din,
  input  wire logic signed [DOT_W-1:0] dout,
  output tpc_pkg::vert_t               res
);
  import tpc_pkg::*;

  logic [DOT_W:0]    rem  [T_FRAC+1];
  logic [DOT_W:0]    den  [T_FRAC+1];
  logic [T_FRAC-1:0] quo  [T_FRAC+1];
  vert_t             pinl [T_FRAC+1];
  dvec_t             dlt  [T_FRAC+1];

  logic signed [DOT_W:0] din_x, dout_x, den_s;

  // divider entry: divisor is din - dout, positive when din is inside and dout outside
  always_comb begin
    din_x  = (DOT_W+1)'(din);
    dout_x = (DOT_W+1)'(dout);
    den_s  = din_x - dout_x;
    rem[0]  = din_x;
    den[0]  = den_s;
    quo[0]  = '0;
    pinl[0] = pin;
    for (int k = 0; k < 4; k++) begin
      dlt[0][k] = 33'($signed(pout[k])) - 33'($signed(pin[k]));
    end
  end

  // one quotient bit per stage
  for (genvar i = 0; i < T_FRAC; i++) begin : g_div
    logic [DOT_W+1:0] sh;
    logic             ge;
    assign sh = {rem[i], 1'b0};
    assign ge = sh >= {1'b0, den[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= ge ? (DOT_W+1)'(sh - {1'b0, den[i]}) : sh[DOT_W:0];
        quo[i+1]  <= {quo[i][T_FRAC-2:0], ge};
        den[i+1]  <= den[i];
        pinl[i+1] <= pinl[i];
        dlt[i+1]  <= dlt[i];
      end
    end
  end

  logic [62:0] mprod [4];
  logic [3:0]  neg;
  vert_t       pin_m;
  logic [32:0] mag [4];

  // magnitude of each coordinate step
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag[k] = dlt[T_FRAC][k][32] ? 33'(-dlt[T_FRAC][k]) : 33'(dlt[T_FRAC][k]);
    end
  end

  // scale the step by t, then offset from the inside vertex
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        mprod[k] <= 63'(mag[k] * quo[T_FRAC]);
        neg[k]   <= dlt[T_FRAC][k][32];
      end
      pin_m <= pinl[T_FRAC];
      for (int k = 0; k < 4; k++) begin
        res[k] <= neg[k] ? 32'(34'($signed(pin_m[k])) - 34'(mprod[k] >> T_FRAC))
                         : 32'(34'($signed(pin_m[k])) + 34'(mprod[k] >> T_FRAC));
      end
    end
  end
endmodule
`default_nettype wire

// File: src/tpc_emit.sv
// merge stage: holds one clipped result and sends its vertices one per cycle
// while out_ready is high; depends on tpc_pkg
`default_nettype none
module tpc_emit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire tpc_pkg::pass_t pass,
  input  wire tpc_pkg::vert_t c0,
  input  wire tpc_pkg::vert_t c1,
  input  wire logic           out_ready,
  output logic                out_valid,
  output tpc_pkg::vert_t      vertex,
  output tpc_pkg::tag_t       tag,
  output logic                done
);
  import tpc_pkg::*;

  logic [2:0] idx;
  pass_t      held;
  vert_t      hc0, hc1;

  assign done = out_valid && out_ready && tag.last;

  // valid and vertex counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (en) begin
      out_valid <= in_valid && (pass.kind != KIND_NONE);
      idx       <= '0;
    end else if (out_valid && out_ready) begin
      idx <= idx + 3'd1;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      held <= pass;
      hc0  <= c0;
      hc1  <= c1;
    end
  end

  // vertex order for each case
  always_comb begin
    vertex = held.p0;
    case (held.kind)
      KIND_ALL: begin
        case (idx)
          3'd1:    vertex = held.p1;
          3'd2:    vertex = held.p2;
          default: vertex = held.p0;
        endcase
      end
      KIND_ONE: begin
        case (idx)
          3'd1:    vertex = hc0;
          3'd2:    vertex = hc1;
          default: vertex = held.p0;
        endcase
      end
      KIND_TWO: begin
        case (idx)
          3'd1:    vertex = held.p1;
          3'd2:    vertex = hc0;
          3'd3:    vertex = held.p1;
          3'd4:    vertex = hc0;
          3'd5:    vertex = hc1;
          default: vertex = held.p0;
        endcase
      end
      default: vertex = held.p0;
    endcase
  end

  // corner, split flag and last marker
  always_comb begin
    if (held.kind == KIND_TWO) begin
      tag.second = idx >= 3'd3;
      tag.corner = (idx >= 3'd3) ? 2'(idx - 3'd3) : idx[1:0];
      tag.last   = idx == 3'd5;
    end else begin
      tag.second = 1'b0;
      tag.corner = idx[1:0];
      tag.last   = idx == 3'd2;
    end
  end
endmodule
`default_nettype wire

// File: src/triangle_plane_clipper.sv
// triangle plane clipper top: register port, dot lanes, crossing lanes, merge stage
// depends on tpc_pkg, tpc_dot, tpc_cross, tpc_emit
//
// Usage: one triangle (three x,y,z,w vertices) enters per s_ transaction; the
// clipped result leaves on m_ as vertices, one per transaction, three or six
// per triangle, none when the triangle is fully outside the plane.
// The plane is to be written over the APB port only while the block is idle; the
// block itself does not enforce this. An accepted triangle passes the dot lanes,
// the classification register and the crossing lanes to the merge stage, which
// offers its first vertex. The output port sends one vertex per cycle while
// m_tready is high, three per triangle and six when it is split in two. The
// 30-stage divider of each crossing lane is fully pipelined, so up to 35 triangles
// are in flight; the merge stage holding the current result sets the rate.
// While a vertex waits with m_tready low the whole pipeline holds and
// s_tready stays low; the held vertex and its tags stay stable.
// Reset clears all valid bits and loads the plane with x = 1.0, w = 1.0.
`default_nettype none
module triangle_plane_clipper #(
  parameter int COORD_FRAC_BITS = tpc_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // a_x a_y a_z a_w b_x b_y b_z b_w c_x c_y c_z c_w, 32 bits each
  input  wire logic [383:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // out_x out_y out_z out_w, 32 bits each
  output logic [127:0]      m_tdata,
  // corner [1:0], tri_second [2]
  output logic [2:0]        m_tuser,
  output logic              m_tlast,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import tpc_pkg::*;

  localparam int DOT_W = 66 - COORD_FRAC_BITS;
  localparam logic [31:0] PLANE_ONE = 32'(1) << COORD_FRAC_BITS;
  localparam logic [1:0] REG_X = 2'd0;
  localparam logic [1:0] REG_Y = 2'd1;
  localparam logic [1:0] REG_Z = 2'd2;
  localparam logic [1:0] REG_W = 2'd3;

  vert_t plane;
  logic  en;
  logic  done;

  // register port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      plane[0] <= PLANE_ONE;
      plane[1] <= '0;
      plane[2] <= '0;
      plane[3] <= PLANE_ONE;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_X:   plane[0] <= pwdata;
        REG_Y:   plane[1] <= pwdata;
        REG_Z:   plane[2] <= pwdata;
        REG_W:   plane[3] <= pwdata;
        default: plane[0] <= plane[0];
      endcase
    end
  end
  assign prdata = plane[paddr[3:2]];

  // pipeline moves whenever the merge stage can take a result
  assign en       = !m_tvalid || done;
  assign s_tready = en;

  // dot product lanes
  vert_t                   vin [3];
  vert_t                   vq  [3];
  logic signed [DOT_W-1:0] d   [3];
  for (genvar i = 0; i < 3; i++) begin : g_dot
    for (genvar k = 0; k < 4; k++) begin : g_unpack
      assign vin[i][k] = s_tdata[(4*i+k)*32 +: 32];
    end
    tpc_dot #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .DOT_W(DOT_W)) u_dot (
      .clk(clk), .en(en), .vert(vin[i]), .plane(plane), .dot(d[i]), .vert_q(vq[i])
    );
  end

  // classification: inside vertices in order, crossing lane operands
  logic [2:0] ins;
  kind_t      kind;
  logic [1:0] ia, ib, l0o, l1i, l1o;
  always_comb begin
    for (int i = 0; i < 3; i++) ins[i] = !d[i][DOT_W-1];
    kind = KIND_NONE;
    ia = 2'd0; ib = 2'd0; l0o = 2'd0; l1i = 2'd0; l1o = 2'd0;
    case (ins)
      3'b111: begin kind = KIND_ALL; ia = 2'd0; ib = 2'd1; end
      3'b001: begin kind = KIND_ONE; ia = 2'd0; l0o = 2'd1; l1i = 2'd0; l1o = 2'd2; end
      3'b010: begin kind = KIND_ONE; ia = 2'd1; l0o = 2'd0; l1i = 2'd1; l1o = 2'd2; end
      3'b100: begin kind = KIND_ONE; ia = 2'd2; l0o = 2'd0; l1i = 2'd2; l1o = 2'd1; end
      3'b011: begin kind = KIND_TWO; ia = 2'd0; ib = 2'd1; l0o = 2'd2; l1i = 2'd1; l1o = 2'd2; end
      3'b101: begin kind = KIND_TWO; ia = 2'd0; ib = 2'd2; l0o = 2'd1; l1i = 2'd2; l1o = 2'd1; end
      3'b110: begin kind = KIND_TWO; ia = 2'd1; ib = 2'd2; l0o = 2'd0; l1i = 2'd2; l1o = 2'd0; end
      default: kind = KIND_NONE;
    endcase
  end

  logic v1, v2, vc;
  pass_t cls;
  vert_t l0_in, l0_out, l1_in, l1_out;
  logic signed [DOT_W-1:0] l0_din, l0_dout, l1_din, l1_dout;

  // stage valid bits ahead of the crossing lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; vc <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid; v2 <= v1; vc <= v2;
    end
  end

  // classified triangle register
  always_ff @(posedge clk) begin
    if (en) begin
      cls.kind <= kind;
      cls.p0   <= vq[ia];
      cls.p1   <= vq[ib];
      cls.p2   <= vq[2];
      l0_in    <= vq[ia];
      l0_out   <= vq[l0o];
      l0_din   <= d[ia];
      l0_dout  <= d[l0o];
      l1_in    <= vq[l1i];
      l1_out   <= vq[l1o];
      l1_din   <= d[l1i];
      l1_dout  <= d[l1o];
    end
  end

  // crossing lanes
  vert_t c0, c1;
  tpc_cross #(.DOT_W(DOT_W)) u_cross0 (
    .clk(clk), .en(en), .pin(l0_in), .pout(l0_out), .din(l0_din), .dout(l0_dout), .res(c0)
  );
  tpc_cross #(.DOT_W(DOT_W)) u_cross1 (
    .clk(clk), .en(en), .pin(l1_in), .pout(l1_out), .din(l1_din), .dout(l1_dout), .res(c1)
  );

  // pass-through vertices delayed to meet the crossing results
  pass_t pline [CROSS_LAT];
  logic [CROSS_LAT-1:0] vline;
  always_ff @(posedge clk) begin
    if (rst) begin
      vline <= '0;
    end else if (en) begin
      vline <= {vline[CROSS_LAT-2:0], vc};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pline[0] <= cls;
      for (int i = 1; i < CROSS_LAT; i++) pline[i] <= pline[i-1];
    end
  end

  // merge stage
  vert_t vout;
  tag_t  tag;
  tpc_emit u_emit (
    .clk(clk), .rst(rst), .en(en), .in_valid(vline[CROSS_LAT-1]),
    .pass(pline[CROSS_LAT-1]), .c0(c0), .c1(c1), .out_ready(m_tready),
    .out_valid(m_tvalid), .vertex(vout), .tag(tag), .done(done)
  );

  assign m_tdata = {vout[3], vout[2], vout[1], vout[0]};
  assign m_tuser = {tag.second, tag.corner};
  assign m_tlast = tag.last;
endmodule
`default_nettype wire

// File: src/tpc_checker.sv
// port-level checks for the triangle plane clipper, bound to the top level
// depends on triangle_plane_clipper ports only
`default_nettype none
module tpc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic       m_tlast,
  input wire logic [2:0] m_tuser
);
  // a stalled vertex stays offered
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("output valid dropped under stall");

  // reset empties the output
  assert property (@(posedge clk) rst |=> !m_tvalid) else $error("output valid after reset");

  // corners run 0..2 only
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[1:0] != 2'd3) else $error("corner out of range");

  // the final vertex of a triangle closes its output triangle
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[1:0] == 2'd2) else $error("last vertex not corner two");
endmodule

bind triangle_plane_clipper tpc_checker u_tpc_checker (.*);
`default_nettype wire
